/* hdl/servo_sweep_controller_core_defines.svh */
// Assertion macros for the checker file of the servo sweep controller.
`ifndef SERVO_SWEEP_CONTROLLER_CORE_DEFINES_SVH
`define SERVO_SWEEP_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define SSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("servo sweep controller check failed");

// Next-cycle implication, sampled on aclk and held off during reset.
`define SSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("servo sweep controller check failed");

`endif

/* hdl/ssc_pkg.sv */
package ssc_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int ANGLE_W  = 9;
    localparam int OFFSET_W = 7;
    localparam int SWEEP_W  = 8;

    localparam logic [OFFSET_W-1:0] OFFSET_CEIL = 7'd90;
    localparam logic [SWEEP_W-1:0]  SWEEP_CEIL  = 8'd180;
    localparam logic [SWEEP_W-1:0]  SWEEP_RESET = 8'd40;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = 7'd91;
    localparam logic [SWEEP_W-1:0]  SWEEP_MAX   = 8'd181;

    // Command characters.
    localparam logic [7:0] CMD_TOGGLE      = 8'h20;  // space
    localparam logic [7:0] CMD_PAUSE_LOWER = 8'h73;  // s
    localparam logic [7:0] CMD_PAUSE_UPPER = 8'h53;  // S
    localparam logic [7:0] CMD_OFFSET_UP   = 8'h5D;  // ]
    localparam logic [7:0] CMD_OFFSET_DOWN = 8'h5B;  // [
    localparam logic [7:0] CMD_SWEEP_UP    = 8'h27;  // single quote
    localparam logic [7:0] CMD_SWEEP_DOWN  = 8'h3B;  // semicolon

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_TICK     = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_UNKNOWN  = 2'd2
    } status_t;

endpackage

/* hdl/servo_sweep_controller_core.sv */
// A request accepted on the input side is held in the input register and then moves
// into the result register, from which it is presented on the result channel.
// Throughput: one request per cycle; the input register takes a new request whenever it
// is empty or hands its request on, which it does when the result register is empty or
// is being drained in the same cycle.
// Reset: aresetn is synchronous and active low. It empties both pipeline registers,
// sets the mode to running, the offset to 0 and the sweep width to 40.
module servo_sweep_controller_core
    import ssc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] command_byte
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] opcode
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [8:0] servo_angle, [9] running, [16:10] offset_angle, [24:17] sweep_width,
    // [31:25] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] command_status
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    // The design is a two-register pipeline. The input register captures the request,
    // and a short block of logic computes the result and the next controller state from
    // it. The controller state only moves when the request moves into the result
    // register, so a stall on the result side freezes everything cleanly.

    // Input register.
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    opcode_t       in_op_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [ANGLE_W-1:0]    out_angle_reg;
    status_t               out_status_reg;
    logic                  out_running_reg;
    logic [OFFSET_W-1:0]   out_offset_reg;
    logic [SWEEP_W-1:0]    out_sweep_reg;

    // Controller state and its next values.
    logic                  running_reg,    running_next;
    logic [OFFSET_W-1:0]   offset_reg,     offset_next;
    logic [SWEEP_W-1:0]    sweep_reg,      sweep_next;
    logic [SWEEP_W-1:0]    position_reg,   position_next;
    logic                  descending_reg, descending_next;
    logic                  in_pass_reg,    in_pass_next;
    logic [OFFSET_W-1:0]   lat_offset_reg, lat_offset_next;
    logic [SWEEP_W-1:0]    lat_sweep_reg,  lat_sweep_next;
    logic [ANGLE_W-1:0]    last_angle_reg, last_angle_next;
    status_t               status_next;

    // Working values of the tick path once a new pass may have been started.
    logic [SWEEP_W-1:0]    pos_start;
    logic                  desc_start;
    logic [OFFSET_W-1:0]   lo_start;
    logic [SWEEP_W-1:0]    ls_start;
    logic [SWEEP_W-1:0]    pos_turn;
    logic                  desc_turn;

    logic advance;

    // The result register is free when it is empty or drained this cycle; the input
    // register hands its request over exactly then.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_op_reg   <= opcode_t'(s_axis_tuser);
        end
    end

    // Command decoding. In a command request, an unrecognized byte leaves every state register untouched.
    always_comb begin
        running_next    = running_reg;
        offset_next     = offset_reg;
        sweep_next      = sweep_reg;
        status_next     = STATUS_ACCEPTED;
        unique case (in_byte_reg)
            CMD_TOGGLE: begin
                running_next = !running_reg;
            end
            CMD_PAUSE_LOWER, CMD_PAUSE_UPPER: begin
                running_next = 1'b0;
            end
            CMD_OFFSET_UP: begin
                if (offset_reg <= OFFSET_CEIL) begin
                    offset_next = offset_reg + 1'b1;
                end
            end
            CMD_OFFSET_DOWN: begin
                if (offset_reg > 7'd1) begin
                    offset_next = offset_reg - 1'b1;
                end
            end
            CMD_SWEEP_UP: begin
                if (sweep_reg <= SWEEP_CEIL) begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            CMD_SWEEP_DOWN: begin
                if (sweep_reg > 8'd1) begin
                    sweep_next = sweep_reg - 1'b1;
                end
            end
            default: begin
                status_next = STATUS_UNKNOWN;
            end
        endcase
        // A tick never changes the mode, the offset or the sweep width.
        if (in_op_reg == OP_TICK) begin
            running_next = running_reg;
            offset_next  = offset_reg;
            sweep_next   = sweep_reg;
            status_next  = STATUS_TICK;
        end
    end

    // Tick path. Without a pass in progress the mode decides: running starts a new
    // pass with the offset and width latched, paused just repeats the offset. The
    // triangle turns around when the rising count reaches the latched width, and the
    // pass ends after the falling count has emitted the offset itself.
    always_comb begin
        pos_start  = position_reg;
        desc_start = descending_reg;
        lo_start   = lat_offset_reg;
        ls_start   = lat_sweep_reg;
        if (!in_pass_reg) begin
            pos_start  = '0;
            desc_start = 1'b0;
            lo_start   = offset_reg;
            ls_start   = sweep_reg;
        end

        pos_turn  = pos_start;
        desc_turn = desc_start;
        if (!desc_start && (pos_start >= ls_start)) begin
            desc_turn = 1'b1;
            pos_turn  = ls_start;
        end

        position_next   = position_reg;
        descending_next = descending_reg;
        in_pass_next    = in_pass_reg;
        lat_offset_next = lat_offset_reg;
        lat_sweep_next  = lat_sweep_reg;
        last_angle_next = last_angle_reg;

        if (in_op_reg == OP_TICK) begin
            if (!in_pass_reg && !running_reg) begin
                last_angle_next = {{(ANGLE_W-OFFSET_W){1'b0}}, offset_reg};
            end else begin
                lat_offset_next = lo_start;
                lat_sweep_next  = ls_start;
                descending_next = desc_turn;
                in_pass_next    = 1'b1;
                last_angle_next = {{(ANGLE_W-SWEEP_W){1'b0}}, pos_turn}
                                + {{(ANGLE_W-OFFSET_W){1'b0}}, lo_start};
                if (!desc_turn) begin
                    position_next = pos_turn + 1'b1;
                end else if (pos_turn == '0) begin
                    position_next = pos_turn;
                    in_pass_next  = 1'b0;
                end else begin
                    position_next = pos_turn - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= 1'b1;
            offset_reg     <= '0;
            sweep_reg      <= SWEEP_RESET;
            position_reg   <= '0;
            descending_reg <= 1'b0;
            in_pass_reg    <= 1'b0;
            lat_offset_reg <= '0;
            lat_sweep_reg  <= SWEEP_RESET;
            last_angle_reg <= '0;
        end else if (in_valid_reg && advance) begin
            running_reg    <= running_next;
            offset_reg     <= offset_next;
            sweep_reg      <= sweep_next;
            position_reg   <= position_next;
            descending_reg <= descending_next;
            in_pass_reg    <= in_pass_next;
            lat_offset_reg <= lat_offset_next;
            lat_sweep_reg  <= lat_sweep_next;
            last_angle_reg <= last_angle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // The result reports the state after the request has been applied.
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_angle_reg   <= last_angle_next;
            out_status_reg  <= status_next;
            out_running_reg <= running_next;
            out_offset_reg  <= offset_next;
            out_sweep_reg   <= sweep_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-ANGLE_W-1-OFFSET_W-SWEEP_W){1'b0}},
                            out_sweep_reg, out_offset_reg, out_running_reg, out_angle_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

/* hdl/ssc_checker.sv */
`include "servo_sweep_controller_core_defines.svh"

module ssc_checker
    import ssc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result holds still.
    `SSC_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // The input side only backs up when the result side is stalled.
    `SSC_ASSERT_NOW(a_ready_only_on_stall, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready)

    // Status code and settings stay within their legal ranges.
    `SSC_ASSERT_NOW(a_fields_in_range, m_axis_tvalid,
        ((m_axis_tuser == STATUS_TICK) || (m_axis_tuser == STATUS_ACCEPTED)
         || (m_axis_tuser == STATUS_UNKNOWN)) && (m_axis_tdata[16:10] <= OFFSET_MAX)
        && (m_axis_tdata[24:17] != 8'd0) && (m_axis_tdata[24:17] <= SWEEP_MAX)
        && (m_axis_tdata[31:25] == 7'd0))

    // Once an accepted request has passed the input register, the result side is valid.
    `SSC_ASSERT_NEXT(a_request_flows, s_axis_tvalid && s_axis_tready,
        ##1 m_axis_tvalid)

endmodule

bind servo_sweep_controller_core ssc_checker u_ssc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
